/* rtl/ids_pkg.sv */
// shared types and constants of the instance distribution selector
package ids_pkg;

	localparam int POLICY_W    = 2;
	localparam int COUNT_REG_W = 5;
	localparam int LETTERS_W   = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int KEY_W       = 8;
	localparam int TGT_W       = 4;
	localparam int FREE_IN_W   = 16;
	localparam int CHOSEN_W    = 4;
	localparam int STATUS_W    = 2;

	// policy codes
	localparam logic [POLICY_W-1:0] POL_ROUND_ROBIN = 2'd0;
	localparam logic [POLICY_W-1:0] POL_KEY_RANGE   = 2'd1;
	localparam logic [POLICY_W-1:0] POL_LEAST_USED  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_INST = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LETTERS = 2'd2;

	// character code just below lower-case a
	localparam logic [KEY_W-1:0] KEY_OFFSET = 8'd96;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load_en;
		logic dec_en;
	} cell_cmd_t;

endpackage

/* rtl/ids_if.sv */
// request and response channel interfaces
interface ids_req_if;
	import ids_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [KEY_W-1:0]     key_first_byte;
	logic [TGT_W-1:0]     target_instance;
	logic [FREE_IN_W-1:0] free_entries;

	modport source (
		output valid, req_type, key_first_byte, target_instance, free_entries,
		input  ready
	);
	modport sink (
		input  valid, req_type, key_first_byte, target_instance, free_entries,
		output ready
	);
endinterface

interface ids_rsp_if;
	import ids_pkg::*;

	logic                valid;
	logic                ready;
	logic [CHOSEN_W-1:0] chosen_instance;
	logic [STATUS_W-1:0] status;

	modport source (
		output valid, chosen_instance, status,
		input  ready
	);
	modport sink (
		input  valid, chosen_instance, status,
		output ready
	);
endinterface

/* rtl/ids_cell.sv */
// one instance slot: free entry count plus one stage of the scan chain
module ids_cell #(
	parameter int INDEX      = 0,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5,
	parameter int FREE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ids_pkg::cell_cmd_t      cmd,
	input  logic [IDX_W-1:0]        sel,
	input  logic [FREE_WIDTH-1:0]   load_val,
	input  logic [CNT_W-1:0]        cnt_eff,
	input  logic                    tok_in_vld,
	input  logic                    tok_in_found,
	input  logic [FREE_WIDTH-1:0]   tok_in_best,
	input  logic [IDX_W-1:0]        tok_in_pick,
	output logic                    tok_out_vld_q,
	output logic                    tok_out_found_q,
	output logic [FREE_WIDTH-1:0]   tok_out_best_q,
	output logic [IDX_W-1:0]        tok_out_pick_q
);
	import ids_pkg::*;

	logic [FREE_WIDTH-1:0] free_q;
	logic                  hit;
	logic                  part;
	logic                  take;

	assign hit  = (sel == IDX_W'(INDEX));
	assign part = (INDEX < int'(cnt_eff));
	// >= lets a later (higher) index win a tie
	assign take = tok_in_vld && part && (free_q != '0) && (free_q >= tok_in_best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q        <= '0;
			tok_out_vld_q <= 1'b0;
		end else begin
			tok_out_vld_q <= tok_in_vld;
			if (cmd.load_en && hit) begin
				free_q <= load_val;
			end else if (cmd.dec_en && hit) begin
				free_q <= free_q - FREE_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_out_found_q <= tok_in_found | take;
		tok_out_best_q  <= take ? free_q : tok_in_best;
		tok_out_pick_q  <= take ? IDX_W'(INDEX) : tok_in_pick;
	end

endmodule

/* rtl/ids_div.sv */
// restoring divider, one quotient bit per cycle
module ids_div #(
	parameter int DVD_W = 8,
	parameter int DVS_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done_q,
	output logic [DVD_W-1:0] quo_q,
	output logic [DVS_W-1:0] rem_q
);
	import ids_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic [DVS_W:0]    shifted;
	logic              ge;
	logic [DVS_W:0]    diff;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

/* rtl/instance_distribution_selector_unit.sv */
// instance distribution selector: top level with config, sequencer and cell chain
//
// Picks the storage instance for a new key under the configured policy, one
// request at a time. A load request (req_type 1) writes the free count of one
// instance and answers through the result register into the response register;
// a distribute request with no instances configured answers the same way.
// Round robin and key range go through a shared restoring divider that makes
// one quotient bit per cycle. Least used sends a scan token down the row of
// MAX_INSTANCES cells, one cell per cycle; the winning cell gives up one entry
// as the token leaves the chain. The next request is taken as soon as the
// result has moved to the response register, even while that result still
// waits for the consumer. Configuration writes are expected only while the
// block is idle.
module instance_distribution_selector_unit #(
	parameter int MAX_INSTANCES = 16,
	parameter int FREE_WIDTH    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ids_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ids_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ids_req_if.sink                        req,
	ids_rsp_if.source                      rsp
);
	import ids_pkg::*;

	localparam int IDX_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
	localparam int CNT_W = $clog2(MAX_INSTANCES + 1);
	localparam int DVS_W = (CNT_W > LETTERS_W) ? CNT_W : LETTERS_W;
	localparam int DVD_W = (CNT_W > KEY_W) ? CNT_W : KEY_W;

	// configuration registers
	logic [POLICY_W-1:0]    policy_q;
	logic [COUNT_REG_W-1:0] count_q;
	logic [LETTERS_W-1:0]   letters_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_ROUND_ROBIN;
			count_q   <= '0;
			letters_q <= LETTERS_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POLICY:  policy_q  <= cfg_wdata[POLICY_W-1:0];
				REG_COUNT:   count_q   <= cfg_wdata[COUNT_REG_W-1:0];
				REG_LETTERS: letters_q <= cfg_wdata[LETTERS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective count and letters per instance
	logic [CNT_W-1:0]     cnt_eff;
	logic [CNT_W-1:0]     cnt_m1;
	logic [LETTERS_W-1:0] per_eff;
	logic [KEY_W-1:0]     letter_m1;
	logic                 tgt_ok;

	assign cnt_eff   = (int'(count_q) > MAX_INSTANCES) ? CNT_W'(MAX_INSTANCES)
	                                                   : CNT_W'(count_q);
	assign cnt_m1    = cnt_eff - CNT_W'(1);
	assign per_eff   = (letters_q == '0) ? LETTERS_W'(1) : letters_q;
	// zero-based letter number, keys at or below the offset map to letter one
	assign letter_m1 = (req.key_first_byte > KEY_OFFSET)
	                 ? req.key_first_byte - KEY_OFFSET - KEY_W'(1) : '0;
	assign tgt_ok    = (int'(req.target_instance) < MAX_INSTANCES);

	// sequencer state
	state_t               state_q, state_d;
	logic                 op_range_q, op_range_d;
	logic [CNT_W-1:0]     ptr_q, ptr_d;
	logic                 ptr_ld;
	logic [CHOSEN_W-1:0]  res_chosen_q, res_chosen_d;
	logic [STATUS_W-1:0]  res_status_q, res_status_d;
	logic                 res_ld;
	logic                 out_ld;
	logic                 out_vld_q;
	logic [CHOSEN_W-1:0]  out_chosen_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic                 in_fire;
	logic                 out_fire;

	// divider
	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;
	logic [DVD_W-1:0] range_pick;

	// cell chain
	cell_cmd_t             cmd;
	logic [IDX_W-1:0]      sel;
	logic [FREE_WIDTH-1:0] load_val;
	logic                  scan_start;
	logic                  tok_vld   [MAX_INSTANCES+1];
	logic                  tok_found [MAX_INSTANCES+1];
	logic [FREE_WIDTH-1:0] tok_best  [MAX_INSTANCES+1];
	logic [IDX_W-1:0]      tok_pick  [MAX_INSTANCES+1];

	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid & req.ready;
	assign out_fire  = rsp.valid & rsp.ready;
	assign load_val  = FREE_WIDTH'(req.free_entries);

	// key range answer saturates at the last instance
	assign range_pick = (div_quo > DVD_W'(cnt_m1)) ? DVD_W'(cnt_m1) : div_quo;

	always_comb begin
		state_d      = state_q;
		op_range_d   = op_range_q;
		div_start    = 1'b0;
		div_dvd      = '0;
		div_dvs      = '0;
		scan_start   = 1'b0;
		cmd          = '0;
		sel          = '0;
		res_ld       = 1'b0;
		res_chosen_d = '0;
		res_status_d = STAT_OK;
		ptr_ld       = 1'b0;
		ptr_d        = ptr_q;
		out_ld       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (req.req_type) begin
						// free count load, out-of-range targets are dropped
						cmd.load_en = tgt_ok;
						sel         = IDX_W'(req.target_instance);
						res_ld      = 1'b1;
						state_d     = S_EMIT;
					end else if (cnt_eff == '0) begin
						res_ld       = 1'b1;
						res_status_d = STAT_NO_INST;
						state_d      = S_EMIT;
					end else if (policy_q == POL_KEY_RANGE) begin
						div_start  = 1'b1;
						div_dvd    = DVD_W'(letter_m1);
						div_dvs    = DVS_W'(per_eff);
						op_range_d = 1'b1;
						state_d    = S_DIV;
					end else if (policy_q == POL_LEAST_USED) begin
						scan_start = 1'b1;
						state_d    = S_SCAN;
					end else begin
						// round robin, also taken by the unused policy code
						div_start  = 1'b1;
						div_dvd    = DVD_W'(ptr_q);
						div_dvs    = DVS_W'(cnt_eff);
						op_range_d = 1'b0;
						state_d    = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					res_ld = 1'b1;
					if (op_range_q) begin
						res_chosen_d = CHOSEN_W'(range_pick);
					end else begin
						// pointer folded into range, answered, then advanced
						res_chosen_d = CHOSEN_W'(div_rem);
						ptr_ld       = 1'b1;
						ptr_d        = CNT_W'(div_rem) + CNT_W'(1);
					end
					state_d = S_EMIT;
				end
			end
			S_SCAN: begin
				if (tok_vld[MAX_INSTANCES]) begin
					res_ld = 1'b1;
					if (tok_found[MAX_INSTANCES]) begin
						cmd.dec_en   = 1'b1;
						sel          = tok_pick[MAX_INSTANCES];
						res_chosen_d = CHOSEN_W'(tok_pick[MAX_INSTANCES]);
					end else begin
						res_status_d = STAT_NO_FREE;
					end
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				// move the result out once the response register is free
				if (!out_vld_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_range_q <= 1'b0;
			ptr_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			op_range_q <= op_range_d;
			if (ptr_ld) begin
				ptr_q <= ptr_d;
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (out_fire) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_chosen_q <= res_chosen_d;
			res_status_q <= res_status_d;
		end
		if (out_ld) begin
			out_chosen_q <= res_chosen_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.chosen_instance = out_chosen_q;
	assign rsp.status          = out_status_q;

	ids_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done_q   (div_done),
		.quo_q    (div_quo),
		.rem_q    (div_rem)
	);

	// scan token enters at cell zero with nothing found yet
	assign tok_vld[0]   = scan_start;
	assign tok_found[0] = 1'b0;
	assign tok_best[0]  = '0;
	assign tok_pick[0]  = '0;

	for (genvar i = 0; i < MAX_INSTANCES; i++) begin : g_cell
		ids_cell #(
			.INDEX      (i),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W),
			.FREE_WIDTH (FREE_WIDTH)
		) u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.cmd             (cmd),
			.sel             (sel),
			.load_val        (load_val),
			.cnt_eff         (cnt_eff),
			.tok_in_vld      (tok_vld[i]),
			.tok_in_found    (tok_found[i]),
			.tok_in_best     (tok_best[i]),
			.tok_in_pick     (tok_pick[i]),
			.tok_out_vld_q   (tok_vld[i+1]),
			.tok_out_found_q (tok_found[i+1]),
			.tok_out_best_q  (tok_best[i+1]),
			.tok_out_pick_q  (tok_pick[i+1])
		);
	end

	// an accepted transaction always moves the sequencer out of idle
	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after an accepted transaction");

	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside of the divide state");

	// scan token reaches the end of the chain only during a scan
	a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_vld[MAX_INSTANCES] |-> state_q == S_SCAN)
		else $error("scan token left the chain outside of a scan");

	// rotation pointer never passes the instance limit
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ptr_q) <= MAX_INSTANCES)
		else $error("rotation pointer out of range");

	// a failed selection answers instance zero
	a_fail_chosen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STAT_NO_FREE || rsp.status == STAT_NO_INST))
		|-> rsp.chosen_instance == '0)
		else $error("failed selection reports a nonzero instance");

endmodule
